// File: rtl/core/brl_pkg.sv
package brl_pkg;

	// command codes carried in the low bits of s_tdata
	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// per-cycle operation of one cell row
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_PULL   = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PURGE,
		ST_INSERT,
		ST_RESP,
		ST_READ
	} state_t;

	// control handed from the sequencer to a row
	typedef struct packed {
		logic     en;
		cell_op_t op;
	} row_ctl_t;

	// configuration register indexes
	localparam logic CFG_LIST_LIMIT = 1'b0;
	localparam logic CFG_UNIQUE     = 1'b1;

	localparam int IdW   = 32;
	localparam int HdlW  = 16;
	localparam int CntW  = 5;
	localparam int InDataW  = 56;
	localparam int OutDataW = 56;

endpackage

// File: rtl/core/brl_cell.sv
module brl_cell
	import brl_pkg::*;
#(
	parameter int CW  = 5,
	parameter int POS = 0
) (
	input  logic            clk,
	input  cell_op_t        op,
	input  logic [CW-1:0]   count,
	input  logic [IdW-1:0]  key,
	input  logic            kill_in,
	input  logic [IdW-1:0]  left_id,
	input  logic [HdlW-1:0] left_hdl,
	input  logic [IdW-1:0]  right_id,
	input  logic [HdlW-1:0] right_hdl,
	input  logic [IdW-1:0]  wrap_id,
	input  logic [HdlW-1:0] wrap_hdl,
	output logic [IdW-1:0]  id,
	output logic [HdlW-1:0] hdl,
	output logic            kill_out
);

	logic [IdW-1:0]  id_q;
	logic [HdlW-1:0] hdl_q;
	logic            occupied;
	logic            tail;
	logic            hit;

	// position inside the live part of the list
	assign occupied = count > CW'(POS);
	assign tail     = count == CW'(POS + 1);
	assign hit      = occupied && (id_q == key);
	assign kill_out = kill_in | hit;

	assign id  = id_q;
	assign hdl = hdl_q;

	// entry register: shift in, close a gap, or rotate for readout
	always_ff @(posedge clk) begin
		unique case (op)
			OP_INSERT: begin
				id_q  <= left_id;
				hdl_q <= left_hdl;
			end
			OP_PULL: begin
				if (kill_out) begin
					id_q  <= right_id;
					hdl_q <= right_hdl;
				end
			end
			OP_ROTATE: begin
				if (tail) begin
					id_q  <= wrap_id;
					hdl_q <= wrap_hdl;
				end else if (occupied) begin
					id_q  <= right_id;
					hdl_q <= right_hdl;
				end
			end
			OP_HOLD: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/brl_row.sv
module brl_row
	import brl_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int CW       = 5
) (
	input  logic            clk,
	input  row_ctl_t        ctl,
	input  logic [CW-1:0]   count,
	input  logic [IdW-1:0]  key,
	input  logic [HdlW-1:0] new_hdl,
	output logic            any_hit,
	output logic [IdW-1:0]  head_id,
	output logic [HdlW-1:0] head_hdl
);

	logic [IdW-1:0]  id_w   [CAPACITY];
	logic [HdlW-1:0] hdl_w  [CAPACITY];
	logic            kill_w [CAPACITY+1];
	cell_op_t        op;

	assign op        = ctl.en ? ctl.op : OP_HOLD;
	assign kill_w[0] = 1'b0;
	assign any_hit   = kill_w[CAPACITY];
	assign head_id   = id_w[0];
	assign head_hdl  = hdl_w[0];

	// cell 0 takes the new item, each cell trades with its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [IdW-1:0]  lid;
		logic [HdlW-1:0] lhdl;
		logic [IdW-1:0]  rid;
		logic [HdlW-1:0] rhdl;

		if (i == 0) begin : g_head
			assign lid  = key;
			assign lhdl = new_hdl;
		end else begin : g_mid
			assign lid  = id_w[i-1];
			assign lhdl = hdl_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign rid  = id_w[i];
			assign rhdl = hdl_w[i];
		end else begin : g_inner
			assign rid  = id_w[i+1];
			assign rhdl = hdl_w[i+1];
		end

		brl_cell #(
			.CW  (CW),
			.POS (i)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.count     (count),
			.key       (key),
			.kill_in   (kill_w[i]),
			.left_id   (lid),
			.left_hdl  (lhdl),
			.right_id  (rid),
			.right_hdl (rhdl),
			.wrap_id   (id_w[0]),
			.wrap_hdl  (hdl_w[0]),
			.id        (id_w[i]),
			.hdl       (hdl_w[i]),
			.kill_out  (kill_w[i+1])
		);
	end

endmodule

// File: rtl/core/bounded_recent_id_list_top.sv
// Sequence: a query passes ST_EXEC, then ST_RESP; a remove passes ST_EXEC, ST_PURGE until no
//   entry matches, then ST_RESP; an add passes ST_EXEC, ST_PURGE in unique mode, ST_INSERT, ST_RESP.
// Readout: after ST_EXEC, ST_READ sends one entry beat per cycle while the output is free (m_tready).
// Throughput: one command at a time; the next beat is taken with the final result beat.
// Reset clears the list counts and loads list_limit 16 and unique_mode 1; entry cells
//   are not cleared and are only read below a list's count.
module bounded_recent_id_list_top
	import brl_pkg::*;
#(
	parameter int CAPACITY  = 16,
	parameter int NUM_LISTS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	// command stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // cmd[1:0], server_id[33:2], name_handle[49:34]
	input  logic                s_tuser,  // list_sel
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // accepted[0], found[1], entry_count[6:2],
	                                      // out_valid[7], out_id[39:8], out_handle[55:40]
	output logic                m_tlast,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [4:0]          cfg_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

	state_t state_q, state_d;

	// latched command
	cmd_t            cmd_q;
	logic            sel_q;
	logic [IdW-1:0]  key_q;
	logic [HdlW-1:0] hdl_q;

	logic [4:0]      list_limit_q;
	logic            unique_q;
	logic [CW-1:0]   cnt_q [NUM_LISTS];
	logic [CW-1:0]   rem_q;
	logic            res_acc_q;
	logic            res_found_q;

	logic                m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;
	logic                m_tlast_q;

	logic            hit_v  [NUM_LISTS];
	logic [IdW-1:0]  hid_v  [NUM_LISTS];
	logic [HdlW-1:0] hhdl_v [NUM_LISTS];

	logic            sel_ok;
	logic [LW-1:0]   row;
	logic [CW-1:0]   cnt_cur;
	logic [CW-1:0]   lim;
	logic            hit;
	logic            out_free;
	logic            empty_add;

	// control strobes
	cell_op_t        row_op;
	logic            cnt_dec;
	logic            cnt_ins;
	logic            res_load;
	logic            res_acc_d;
	logic            res_found_d;
	logic            out_resp;
	logic            out_read;

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;

	assign sel_ok    = 32'(sel_q) < NUM_LISTS;
	assign row       = sel_ok ? LW'(sel_q) : '0;
	assign cnt_cur   = cnt_q[row];
	assign hit       = hit_v[row];
	assign out_free  = !m_tvalid_q || m_tready;
	assign empty_add = (cmd_q == CMD_ADD) && (hdl_q == '0);

	// effective limit: zero or above capacity means full capacity
	always_comb begin
		if (list_limit_q == 5'd0 || 32'(list_limit_q) > CAPACITY) begin
			lim = CW'(CAPACITY);
		end else begin
			lim = CW'(list_limit_q);
		end
	end

	// one cell row per list
	for (genvar r = 0; r < NUM_LISTS; r++) begin : g_row
		row_ctl_t ctl;

		assign ctl.en = row == LW'(r);
		assign ctl.op = row_op;

		brl_row #(
			.CAPACITY (CAPACITY),
			.CW       (CW)
		) u_row (
			.clk      (clk),
			.ctl      (ctl),
			.count    (cnt_q[r]),
			.key      (key_q),
			.new_hdl  (hdl_q),
			.any_hit  (hit_v[r]),
			.head_id  (hid_v[r]),
			.head_hdl (hhdl_v[r])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!sel_ok) begin
					state_d = ST_RESP;
				end else begin
					unique case (cmd_q)
						CMD_ADD: begin
							if (empty_add)     state_d = ST_RESP;
							else if (unique_q) state_d = ST_PURGE;
							else               state_d = ST_INSERT;
						end
						CMD_REMOVE: state_d = ST_PURGE;
						CMD_QUERY:  state_d = ST_RESP;
						CMD_READ:   state_d = (cnt_cur == '0) ? ST_RESP : ST_READ;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_PURGE: begin
				if (!hit) state_d = (cmd_q == CMD_ADD) ? ST_INSERT : ST_RESP;
			end
			ST_INSERT: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_READ: begin
				if (out_free && rem_q == CW'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		row_op      = OP_HOLD;
		cnt_dec     = 1'b0;
		cnt_ins     = 1'b0;
		res_load    = 1'b0;
		res_acc_d   = 1'b0;
		res_found_d = 1'b0;
		out_resp    = 1'b0;
		out_read    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_EXEC: begin
				res_load    = 1'b1;
				res_acc_d   = sel_ok && !empty_add;
				res_found_d = sel_ok && (cmd_q == CMD_QUERY) && hit;
				// a full list drops its oldest entry before the add
				cnt_dec     = sel_ok && (cmd_q == CMD_ADD) && !empty_add &&
				              (cnt_cur >= lim) && (cnt_cur != '0);
			end
			ST_PURGE: begin
				if (hit) begin
					row_op  = OP_PULL;
					cnt_dec = 1'b1;
				end
			end
			ST_INSERT: begin
				row_op  = OP_INSERT;
				cnt_ins = 1'b1;
			end
			ST_RESP: begin
				out_resp = out_free;
			end
			ST_READ: begin
				if (out_free) begin
					row_op   = OP_ROTATE;
					out_read = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			list_limit_q <= 5'd16;
			unique_q     <= 1'b1;
			m_tvalid_q   <= 1'b0;
			for (int r = 0; r < NUM_LISTS; r++) cnt_q[r] <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_LIST_LIMIT: list_limit_q <= cfg_data;
					CFG_UNIQUE:     unique_q     <= cfg_data[0];
					default: begin
					end
				endcase
			end

			for (int r = 0; r < NUM_LISTS; r++) begin
				if (row == LW'(r) && sel_ok) begin
					if (cnt_dec) begin
						cnt_q[r] <= cnt_q[r] - CW'(1);
					end else if (cnt_ins) begin
						cnt_q[r] <= (cnt_q[r] >= CW'(CAPACITY)) ? CW'(CAPACITY)
						                                         : cnt_q[r] + CW'(1);
					end
				end
			end

			if (out_resp || out_read) m_tvalid_q <= 1'b1;
			else if (m_tready)        m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd_t'(s_tdata[1:0]);
			sel_q <= s_tuser;
			key_q <= s_tdata[33:2];
			hdl_q <= s_tdata[49:34];
		end

		if (res_load) begin
			res_acc_q   <= res_acc_d;
			res_found_q <= res_found_d;
			rem_q       <= cnt_cur;
		end else if (out_read) begin
			rem_q <= rem_q - CW'(1);
		end

		if (out_resp) begin
			m_tdata_q <= {HdlW'(0), IdW'(0), 1'b0,
			              sel_ok ? CntW'(cnt_cur) : CntW'(0),
			              res_found_q, res_acc_q};
			m_tlast_q <= 1'b1;
		end else if (out_read) begin
			m_tdata_q <= {hhdl_v[row], hid_v[row], 1'b1, CntW'(cnt_cur), 1'b0, 1'b1};
			m_tlast_q <= rem_q == CW'(1);
		end
	end

endmodule
